FILE: rtl/sptd_pkg.sv
// Shared types, constants and the byte-wise CRC-8 step for the scratchpad
// temperature decoder. No dependencies.
`default_nettype none

package sptd_pkg;

  // scratchpad layout and frame bookkeeping
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] IDX_TEMP_LO  = 4'd0;
  localparam logic [IdxW-1:0] IDX_TEMP_HI  = 4'd1;
  localparam logic [IdxW-1:0] IDX_CONFIG   = 4'd4;
  localparam logic [IdxW-1:0] IDX_CNT_REM  = 4'd6;
  localparam logic [IdxW-1:0] IDX_CNT_PER  = 4'd7;
  localparam logic [IdxW-1:0] IDX_CRC      = 4'd8;

  // family codes and magic values
  localparam logic [7:0] FAMILY_RESET = 8'h28;
  localparam logic [7:0] FAMILY_RES_A = 8'h28;
  localparam logic [7:0] FAMILY_RES_B = 8'h22;
  localparam logic [7:0] CPD_MAGIC    = 8'h10;
  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [15:0] FRAC_MASK   = 16'hFFF0;
  localparam logic [15:0] CR_BIAS     = 16'd12;

  // resolution codes from config byte bits 6..5
  localparam logic [1:0] RES_9BIT  = 2'd0;
  localparam logic [1:0] RES_10BIT = 2'd1;
  localparam logic [1:0] RES_11BIT = 2'd2;
  localparam logic [1:0] RES_12BIT = 2'd3;

  // captured frame contents handed to the conversion stage
  typedef struct packed {
    logic [15:0] temp_raw;
    logic [1:0]  res_bits;
    logic [7:0]  count_remain;
    logic        cpd_ok;
    logic [7:0]  crc;
  } frame_info_t;

  // one byte through the reflected CRC-8, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] b);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sptd_if.sv
// Valid/ready channel interfaces: scratchpad byte input, decoded result
// output and family-code write port. Depends on nothing.
`default_nettype none

interface sptd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface sptd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_sixteenths;
  logic               crc_ok;
  modport source (output valid, temperature_sixteenths, crc_ok, input ready);
  modport sink   (input valid, temperature_sixteenths, crc_ok, output ready);
endinterface

interface sptd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sptd_frame.sv
// Frame tracker: byte position, running CRC-8 and capture of the bytes the
// conversion needs. Depends on sptd_pkg.
`default_nettype none

module sptd_frame (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 frame_start,
  output logic                      last,
  output sptd_pkg::frame_info_t     info
);
  import sptd_pkg::*;

  logic [IdxW-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      temp_lo_r, temp_hi_r, count_remain_r;
  logic [1:0]      res_bits_r;
  logic            cpd_ok_r;
  logic [IdxW-1:0] idx;
  logic [7:0]      crc_cur;

  // frame start restarts position and crc
  assign idx     = frame_start ? '0 : byte_index_r;
  assign crc_cur = frame_start ? '0 : crc_r;
  assign last    = (idx >= IDX_CRC);

  assign info.temp_raw     = {temp_hi_r, temp_lo_r};
  assign info.res_bits     = res_bits_r;
  assign info.count_remain = count_remain_r;
  assign info.cpd_ok       = cpd_ok_r;
  assign info.crc          = crc_cur;

  // next position and crc
  always_comb begin
    if (last) begin
      byte_index_nxt = '0;
      crc_nxt        = '0;
    end else begin
      byte_index_nxt = idx + 1'b1;
      crc_nxt        = crc8_byte(crc_cur, data_byte);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      crc_r        <= '0;
    end else if (fire) begin
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // captured scratchpad bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_lo_r      <= '0;
      temp_hi_r      <= '0;
      res_bits_r     <= '0;
      count_remain_r <= '0;
      cpd_ok_r       <= 1'b0;
    end else if (fire) begin
      unique case (idx)
        IDX_TEMP_LO: temp_lo_r      <= data_byte;
        IDX_TEMP_HI: temp_hi_r      <= data_byte;
        IDX_CONFIG:  res_bits_r     <= data_byte[6:5];
        IDX_CNT_REM: count_remain_r <= data_byte;
        IDX_CNT_PER: cpd_ok_r       <= (data_byte == CPD_MAGIC);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sptd_convert.sv
// Conversion to sixteenths of a degree, crc check and the result register
// with its handshake. Depends on sptd_pkg and sptd_if.
`default_nettype none

module sptd_convert (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire logic [7:0]            crc_byte,
  input  wire logic [7:0]            family_code,
  input  wire sptd_pkg::frame_info_t info,
  output logic                       hold,
  sptd_out_if.source                 out_ch
);
  import sptd_pkg::*;

  logic        out_valid_r;
  logic [15:0] temp_r, temp_nxt;
  logic        crc_ok_r;
  logic [15:0] v3;
  logic        res_family;

  assign res_family = (family_code == FAMILY_RES_A) || (family_code == FAMILY_RES_B);
  assign v3         = info.temp_raw << 3;

  // scale by family and resolution
  always_comb begin
    if (res_family) begin
      case (info.res_bits)
        RES_9BIT:  temp_nxt = v3;
        RES_10BIT: temp_nxt = info.temp_raw << 2;
        RES_11BIT: temp_nxt = info.temp_raw << 1;
        RES_12BIT: temp_nxt = info.temp_raw;
        default:   temp_nxt = info.temp_raw;
      endcase
    end else if (info.cpd_ok) begin
      temp_nxt = (v3 & FRAC_MASK) + CR_BIAS - {8'd0, info.count_remain};
    end else begin
      temp_nxt = v3;
    end
  end

  // result register stalls only while the sink holds off
  assign hold = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold) begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !hold) begin
      temp_r   <= temp_nxt;
      crc_ok_r <= (info.crc == crc_byte);
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.temperature_sixteenths = signed'(temp_r);
  assign out_ch.crc_ok                 = crc_ok_r;

endmodule

`default_nettype wire

FILE: rtl/scratchpad_temperature_decoder.sv
// Top level of the scratchpad temperature decoder: input register, family
// code register, frame tracker and conversion stage. Depends on sptd_pkg,
// sptd_if, sptd_frame and sptd_convert.
//
// Usage: feed the nine scratchpad bytes on in_ch, one request per byte, with
// frame_start set on byte 0 to resynchronize. After byte 8 the position
// wraps to 0 by itself. Only byte 8 yields a request on out_ch: the signed
// temperature in 1/16 degree and crc_ok (crc of bytes 0..7 equals byte 8).
// cfg_ch writes the family code (reset 0x28); it is always ready. The code
// must be written only while the block is idle; the block does not enforce
// this. A request on byte 8 passes the input register, then the result
// register, before it can leave on out_ch. Throughput: one byte per cycle,
// set by the combinational crc step and conversion between the two
// registers. When the receiver stalls, the result register holds; bytes 0..7
// keep flowing, and a later byte 8 waits in the input register until the
// result register frees. Reset clears the position, crc and captured bytes.
`default_nettype none

module scratchpad_temperature_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sptd_in_if.sink    in_ch,
  sptd_out_if.source out_ch,
  sptd_cfg_if.sink   cfg_ch
);
  import sptd_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic [7:0]  family_r;
  logic        last;
  logic        hold;
  logic        s1_adv;
  frame_info_t info;

  // input register advances unless a final byte meets a stalled result register
  assign s1_adv      = s1_valid_r && !(last && hold);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.frame_start;
    end
  end

  // family code register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= FAMILY_RESET;
    end else if (cfg_ch.valid) begin
      family_r <= cfg_ch.data;
    end
  end

  sptd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_adv),
    .data_byte   (s1_byte_r),
    .frame_start (s1_start_r),
    .last        (last),
    .info        (info)
  );

  sptd_convert u_convert (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (s1_adv && last),
    .crc_byte    (s1_byte_r),
    .family_code (family_r),
    .info        (info),
    .hold        (hold),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/sv/sptd_reading_check.sv
// Result predictor and comparator for the scratchpad temperature decoder.
// Depends on sptd_pkg; also holds the small crc helper package shared with the bench top.
`timescale 1ns / 100ps

package sptd_tb_crc_pkg;
  import sptd_pkg::CRC_POLY;

  // reflected crc-8 over one byte, data folded in up front
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

module sptd_reading_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_temperature_sixteenths,
  input  logic               out_crc_ok,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 error_count,
  output int                 results_owed
);
  import sptd_pkg::*;
  import sptd_tb_crc_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               crc_ok;
  } reading_t;

  reading_t   readings_q[$];
  int         mismatches;

  // shadow copy of the decoder state
  logic [7:0] family_code;
  logic [3:0] byte_pos;
  logic [7:0] crc_run;
  logic [7:0] temp_lo;
  logic [7:0] temp_hi;
  logic [1:0] res_bits;
  logic [7:0] cnt_remain;
  logic       cpd_ok;

  // scale the captured raw value to sixteenths, 16-bit wrap
  function automatic logic [15:0] scaled_temp();
    logic [15:0] v;
    v = {temp_hi, temp_lo};
    if (family_code == FAMILY_RES_A || family_code == FAMILY_RES_B) begin
      case (res_bits)
        RES_9BIT:  v = v << 3;
        RES_10BIT: v = v << 2;
        RES_11BIT: v = v << 1;
        default:   v = v;
      endcase
    end else begin
      v = v << 3;
      if (cpd_ok) begin
        v = (v & FRAC_MASK) + CR_BIAS - {8'h00, cnt_remain};
      end
    end
    return v;
  endfunction

  // advance the shadow state by one accepted byte
  task automatic take_byte(input logic [7:0] b, input logic fs);
    reading_t r;
    if (fs) begin
      byte_pos = '0;
      crc_run  = '0;
    end
    if (byte_pos >= IDX_CRC) begin
      r.temp   = scaled_temp();
      r.crc_ok = (crc_run == b);
      readings_q.push_back(r);
      byte_pos = '0;
      crc_run  = '0;
    end else begin
      case (byte_pos)
        IDX_TEMP_LO: temp_lo    = b;
        IDX_TEMP_HI: temp_hi    = b;
        IDX_CONFIG:  res_bits   = b[6:5];
        IDX_CNT_REM: cnt_remain = b;
        IDX_CNT_PER: cpd_ok     = (b == CPD_MAGIC);
        default: ;
      endcase
      crc_run  = crc8_next(crc_run, b);
      byte_pos = byte_pos + 4'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      readings_q.delete();
      mismatches  = 0;
      family_code = FAMILY_RESET;
      byte_pos    = '0;
      crc_run     = '0;
      temp_lo     = '0;
      temp_hi     = '0;
      res_bits    = '0;
      cnt_remain  = '0;
      cpd_ok      = 1'b0;
    end else begin
      // compare each delivered reading with the oldest prediction
      if (out_valid && out_ready) begin
        got.temp   = out_temperature_sixteenths;
        got.crc_ok = out_crc_ok;
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected reading: temp %0d crc_ok %0b", $time, got.temp,
                   got.crc_ok);
          mismatches++;
        end else begin
          want = readings_q.pop_front();
          if (got.temp !== want.temp) begin
            $display("%0t: temperature mismatch: expected %0d, actual %0d", $time,
                     want.temp, got.temp);
            mismatches++;
          end
          if (got.crc_ok !== want.crc_ok) begin
            $display("%0t: crc_ok mismatch: expected %0b, actual %0b", $time,
                     want.crc_ok, got.crc_ok);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_byte(in_data_byte, in_frame_start);
      end
      if (cfg_valid && cfg_ready) begin
        family_code = cfg_data;
      end
    end
    error_count  <= mismatches;
    results_owed <= readings_q.size();
  end

endmodule

FILE: tb/sv/tb_scratchpad_temperature_decoder.sv
// Bench top for the scratchpad temperature decoder: clock, reset, byte and
// family-code stimulus, receiver stalls and the verdict. Depends on sptd_pkg,
// sptd_if, sptd_reading_check and the decoder itself.
`timescale 1ns / 100ps

module tb_scratchpad_temperature_decoder;
  import sptd_pkg::*;
  import sptd_tb_crc_pkg::*;

  localparam int         QUIET_LIMIT  = 500;
  localparam int         PHASE_BYTES  = 75;
  localparam int         NUM_PHASES   = 6;
  localparam logic [7:0] FAMILY_PLAIN = 8'h10;
  localparam logic [7:0] FAMILY_MIN   = 8'h00;
  localparam logic [7:0] FAMILY_MAX   = 8'hFF;

  typedef logic [7:0] pad_t [9];

  logic clk;
  logic rst_n;
  logic calm;
  int   error_count;
  int   results_owed;
  int   bytes_sent;
  int   quiet_cycles;
  bit   in_sync;

  sptd_in_if  in_ch ();
  sptd_out_if out_ch ();
  sptd_cfg_if cfg_ch ();

  scratchpad_temperature_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sptd_reading_check reading_check (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_ch.valid),
    .in_ready                   (in_ch.ready),
    .in_data_byte               (in_ch.data_byte),
    .in_frame_start             (in_ch.frame_start),
    .out_valid                  (out_ch.valid),
    .out_ready                  (out_ch.ready),
    .out_temperature_sixteenths (out_ch.temperature_sixteenths),
    .out_crc_ok                 (out_ch.crc_ok),
    .cfg_valid                  (cfg_ch.valid),
    .cfg_ready                  (cfg_ch.ready),
    .cfg_data                   (cfg_ch.data),
    .error_count                (error_count),
    .results_owed               (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted request anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls in short random bursts
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one byte request, with an optional idle burst ahead of it
  task automatic push_byte(input logic [7:0] b, input logic fs);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic push_frame(input pad_t fr, input bit fs0);
    for (int i = 0; i < 9; i++) begin
      push_byte(fr[i], (i == 0) ? fs0 : 1'b0);
    end
  endtask

  // fill byte 8 with the crc of bytes 0..7, or a wrong one
  task automatic seal_frame(inout pad_t fr, input bit good);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      crc = crc8_next(crc, fr[i]);
    end
    fr[8] = good ? crc : (crc ^ 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [7:0] temp_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_frame(output pad_t fr);
    for (int i = 0; i < 8; i++) begin
      fr[i] = 8'($urandom_range(0, 255));
    end
    fr[0] = temp_byte();
    fr[1] = temp_byte();
    if ($urandom_range(0, 1) == 0) begin
      fr[7] = CPD_MAGIC;
    end
    seal_frame(fr, $urandom_range(0, 3) != 0);
  endtask

  // hold the sender until every reading is out and the pipe is empty
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_family(input logic [7:0] code);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    pad_t       fr;
    logic [7:0] families [NUM_PHASES];
    int         phase_end;
    int         burst;

    families = '{FAMILY_RESET, FAMILY_RES_B, FAMILY_PLAIN, FAMILY_MIN, FAMILY_MAX,
                 FAMILY_RES_A};
    calm              = 1'b0;
    bytes_sent        = 0;
    in_sync           = 1'b1;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.frame_start <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 12-bit frame with good crc at the reset family code
    fr = '{8'hD0, 8'h07, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, CPD_MAGIC, 8'h00};
    seal_frame(fr, 1'b1);
    push_frame(fr, 1'b1);
    // most negative raw value, bad crc, frame entered by wrap-around only
    fr = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, CPD_MAGIC, 8'h00};
    seal_frame(fr, 1'b0);
    push_frame(fr, 1'b0);
    // aborted frame, then resync with frame_start at 10-bit resolution
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    fr = '{8'hFF, 8'h7F, 8'hA5, 8'h5A, 8'h20, 8'hFF, 8'h0F, 8'h0F, 8'h00};
    seal_frame(fr, 1'b1);
    push_frame(fr, 1'b1);

    // random phases, one family code each
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      if (p > 0) begin
        write_family(families[p]);
      end
      if (p == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: short bursts of arbitrary bytes and frame marks
          burst = $urandom_range(1, 8);
          for (int i = 0; i < burst; i++) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          end
          in_sync = 1'b0;
        end else begin
          random_frame(fr);
          push_frame(fr, !in_sync || $urandom_range(0, 2) != 0);
          in_sync = 1'b1;
        end
      end
    end

    settle_idle();
    repeat (6) @(posedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sptd_pkg.sv
rtl/sptd_if.sv
rtl/sptd_frame.sv
rtl/sptd_convert.sv
rtl/scratchpad_temperature_decoder.sv
tb/sv/sptd_reading_check.sv
tb/sv/tb_scratchpad_temperature_decoder.sv
